// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms, reset disables checking
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lcs_len_pkg.sv
// ----------------------------------------------------------------------------
// lcs_len_pkg
// shared widths and the control bundle broadcast to every cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcs_len_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned MATCH_W   = 7;
  localparam int unsigned MATCH_MAX = 127;

  typedef struct packed {
    logic              clr_all;   // new pattern: clear runs and maxima
    logic              wr;        // store a pattern character
    logic              upd;       // text character present
    logic              first;     // first text character of a text
    logic              text_end;  // last text item, clear runs
    logic              fold;      // fold maxima toward cell 0
    logic              clr_best;  // result taken, clear maxima
    logic [CHAR_W-1:0] ch;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/lcs_len_cell.sv
// ----------------------------------------------------------------------------
// lcs_len_cell
// one pattern position: stored character, diagonal run and local maximum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcs_len_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned LEN_W = 7,
  parameter int unsigned RUN_W = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lcs_len_pkg::cell_ctrl_t ctrl_i,
  input  logic [LEN_W-1:0]        len_i,
  input  logic [RUN_W-1:0]        left_run_i,
  output logic [RUN_W-1:0]        run_o,
  input  logic [RUN_W-1:0]        right_best_i,
  output logic [RUN_W-1:0]        best_o
);
  import lcs_len_pkg::*;

  logic [CHAR_W-1:0] pchar_q;
  logic [RUN_W-1:0]  run_q, run_d;
  logic [RUN_W-1:0]  best_q, best_d;
  logic [RUN_W-1:0]  run_new;
  logic [RUN_W-1:0]  left_eff;
  logic              active;
  logic              hit;

  assign active   = LEN_W'(IDX) < len_i;
  assign hit      = active && (pchar_q == ctrl_i.ch);
  assign left_eff = ctrl_i.first ? '0 : left_run_i;
  assign run_new  = hit ? (left_eff + RUN_W'(1)) : '0;

  always_comb begin
    run_d  = run_q;
    best_d = best_q;
    if (ctrl_i.clr_all) begin
      run_d  = '0;
      best_d = '0;
    end else if (ctrl_i.upd || ctrl_i.text_end) begin
      if (ctrl_i.upd) begin
        run_d = run_new;
        if (run_new > best_q) begin
          best_d = run_new;
        end
      end
      if (ctrl_i.text_end) begin
        run_d = '0;
      end
    end else if (ctrl_i.fold) begin
      if (right_best_i > best_q) begin
        best_d = right_best_i;
      end
    end else if (ctrl_i.clr_best) begin
      best_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      best_q <= '0;
    end else begin
      run_q  <= run_d;
      best_q <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr && (len_i == LEN_W'(IDX))) begin
      pchar_q <= ctrl_i.ch;
    end
  end

  assign run_o  = run_q;
  assign best_o = best_q;

endmodule

// File: hw/rtl/lcs_len_ctrl.sv
// ----------------------------------------------------------------------------
// lcs_len_ctrl
// item decode, pattern length, fold sequencing and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lcs_len_ctrl #(
  parameter int unsigned MAX_LEN = 64,
  parameter int unsigned LEN_W   = 7,
  parameter int unsigned RUN_W   = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [lcs_len_pkg::CHAR_W-1:0]      ch_i,
  input  logic                                has_char_i,
  input  logic                                is_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lcs_len_pkg::MATCH_W-1:0]     match_len_o,
  output logic                                pattern_overflow_o,
  output lcs_len_pkg::cell_ctrl_t             cell_ctrl_o,
  output logic [LEN_W-1:0]                    len_o,
  input  logic [RUN_W-1:0]                    best0_i
);
  import lcs_len_pkg::*;

  localparam int unsigned CNT_W = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CMP_W = (RUN_W > MATCH_W) ? RUN_W : MATCH_W;

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_FOLD = 3'b010,
    S_DONE = 3'b100
  } lcs_state_e;

  lcs_state_e         state_q, state_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               ovf_q, ovf_d;
  logic               complete_q, complete_d;
  logic               first_q, first_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [MATCH_W-1:0] match_q, match_d;
  logic               oflag_q, oflag_d;

  logic               acc;
  logic               out_free;
  logic [LEN_W-1:0]   eff_len;
  logic [CMP_W-1:0]   best_ext;
  logic [MATCH_W-1:0] best_sat;

  assign in_ready_o = (state_q == S_RUN);
  assign acc        = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign eff_len    = complete_q ? '0 : len_q;
  assign best_ext   = CMP_W'(best0_i);
  assign best_sat   = (best_ext > CMP_W'(MATCH_MAX)) ? MATCH_W'(MATCH_MAX)
                                                     : best_ext[MATCH_W-1:0];

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    complete_d  = complete_q;
    first_d     = first_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    match_d     = match_q;
    oflag_d     = oflag_q;
    cell_ctrl_o = '0;
    cell_ctrl_o.ch    = ch_i;
    cell_ctrl_o.first = first_q;
    len_o       = req_type_i ? len_q : eff_len;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_RUN: begin
        if (acc && !req_type_i) begin
          if (complete_q) begin
            ovf_d               = 1'b0;
            complete_d          = 1'b0;
            first_d             = 1'b1;
            len_d               = '0;
            cell_ctrl_o.clr_all = 1'b1;
          end
          if (has_char_i) begin
            if (eff_len < LEN_W'(MAX_LEN)) begin
              cell_ctrl_o.wr = 1'b1;
              len_d          = eff_len + LEN_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (is_last_i) begin
            complete_d = 1'b1;
          end
        end else if (acc) begin
          if (has_char_i) begin
            cell_ctrl_o.upd = 1'b1;
            first_d         = 1'b0;
          end
          if (is_last_i) begin
            cell_ctrl_o.text_end = 1'b1;
            first_d              = 1'b1;
            cnt_d                = '0;
            state_d              = S_FOLD;
          end
        end
      end
      S_FOLD: begin
        cell_ctrl_o.fold = 1'b1;
        cnt_d            = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MAX_LEN - 2)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          match_d              = best_sat;
          oflag_d              = ovf_q;
          cell_ctrl_o.clr_best = 1'b1;
          state_d              = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      complete_q  <= 1'b0;
      first_q     <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      complete_q  <= complete_d;
      first_q     <= first_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
    oflag_q <= oflag_d;
  end

  assign out_valid_o        = out_valid_q;
  assign match_len_o        = match_q;
  assign pattern_overflow_o = oflag_q;

  `ASSERT_NEXT(a_text_end_folds, acc && req_type_i && is_last_i, state_q == S_FOLD,
    "text end did not start the fold")
  `ASSERT_CLK(a_ovf_full, !ovf_q || (len_q == LEN_W'(MAX_LEN)),
    "overflow flagged with pattern not full")
  `ASSERT_CLK(a_len_bound, len_q <= LEN_W'(MAX_LEN), "pattern length beyond cell count")
  `ASSERT_CLK(a_fold_cnt, (state_q != S_FOLD) || (cnt_q <= CNT_W'(MAX_LEN - 2)),
    "fold counter ran past the chain")

endmodule

// File: hw/rtl/longest_common_substring_len_top.sv
// ----------------------------------------------------------------------------
// longest_common_substring_len_top
// longest common substring length over a chain of pattern cells
// ----------------------------------------------------------------------------
//  channel   dir  tdata                               tuser     tlast
//  s_axis    in   [7:0] ch, [8] has_char              req_type  is_last
//  m_axis    out  [6:0] match_len, [7] pattern_ovf    -         -
//
//  one pattern or text item per cycle; each text character updates all
//  cells at once
//  the last text item starts a fold of the cell maxima toward cell 0,
//  then the result register is loaded from cell 0
//  s_axis_tready_o is low during the fold and while the result waits for
//  a free output register
//  reset clears all control state, runs and maxima at once
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module longest_common_substring_len_top #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] ch, [8] has_char
  input  logic        s_axis_tuser_i,   // req_type
  input  logic        s_axis_tlast_i,   // is_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o   // [6:0] match_len, [7] pattern_overflow
);
  import lcs_len_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned RUN_W = $clog2(MAX_LEN + 1);

  cell_ctrl_t         cell_ctrl;
  logic [LEN_W-1:0]   len_bus;
  logic [RUN_W-1:0]   run_w  [MAX_LEN];
  logic [RUN_W-1:0]   best_w [MAX_LEN];
  logic [MATCH_W-1:0] match_len;
  logic               pattern_overflow;

  lcs_len_ctrl #(
    .MAX_LEN (MAX_LEN),
    .LEN_W   (LEN_W),
    .RUN_W   (RUN_W)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (s_axis_tvalid_i),
    .in_ready_o         (s_axis_tready_o),
    .req_type_i         (s_axis_tuser_i),
    .ch_i               (s_axis_tdata_i[CHAR_W-1:0]),
    .has_char_i         (s_axis_tdata_i[CHAR_W]),
    .is_last_i          (s_axis_tlast_i),
    .out_valid_o        (m_axis_tvalid_o),
    .out_ready_i        (m_axis_tready_i),
    .match_len_o        (match_len),
    .pattern_overflow_o (pattern_overflow),
    .cell_ctrl_o        (cell_ctrl),
    .len_o              (len_bus),
    .best0_i            (best_w[0])
  );

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    logic [RUN_W-1:0] left_run;
    logic [RUN_W-1:0] right_best;

    if (g == 0) begin : g_head
      assign left_run = '0;
    end else begin : g_mid
      assign left_run = run_w[g-1];
    end

    if (g == MAX_LEN - 1) begin : g_tail
      assign right_best = '0;
    end else begin : g_body
      assign right_best = best_w[g+1];
    end

    lcs_len_cell #(
      .IDX   (g),
      .LEN_W (LEN_W),
      .RUN_W (RUN_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .len_i        (len_bus),
      .left_run_i   (left_run),
      .run_o        (run_w[g]),
      .right_best_i (right_best),
      .best_o       (best_w[g])
    );
  end

  assign m_axis_tdata_o = {pattern_overflow, match_len};

endmodule

// File: tb/sv/tb_longest_common_substring_len_top.sv
// ----------------------------------------------------------------------------
// tb_longest_common_substring_len_top
// self-checking bench for the streaming longest common substring block
// ----------------------------------------------------------------------------
//  pattern and text strings are queued up front, first a short directed
//  set, then random strings over narrow and full byte alphabets with
//  copied pattern slices so long matches and pattern overflow occur
//  every accepted item is fed to a local model that predicts the match
//  length and overflow flag; results are checked in order as they leave
//  both stream sides idle in random bursts, with none near the end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_longest_common_substring_len_top;
  import lcs_len_pkg::*;

  localparam int unsigned MAX_LEN   = 64;
  localparam int unsigned N_ITEMS   = 400;
  localparam int unsigned MIN_TEXTS = 20;
  localparam int unsigned CALM_LEFT = 40;

  typedef enum logic {
    REQ_PATTERN = 1'b0,
    REQ_TEXT    = 1'b1
  } req_kind_e;

  typedef struct packed {
    req_kind_e         kind;
    logic [CHAR_W-1:0] ch;
    logic              has_char;
    logic              is_last;
  } lcs_item_t;

  typedef struct packed {
    logic               overflow;
    logic [MATCH_W-1:0] match_len;
  } lcs_result_t;

  typedef logic [CHAR_W-1:0] char_q_t[$];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata_o;

  lcs_item_t   pending_q[$];
  lcs_result_t expected_q[$];
  int unsigned n_err = 0;
  int unsigned n_real = 0;
  int unsigned n_texts = 0;

  // local copy of the block state
  logic [CHAR_W-1:0] pat_mem[MAX_LEN];
  int unsigned       run_row[MAX_LEN] = '{default: 0};
  int unsigned       pat_len = 0;
  int unsigned       best_run = 0;
  bit                first_row = 1'b1;
  bit                ovf_seen = 1'b0;
  bit                pat_done = 1'b0;

  longest_common_substring_len_top #(
    .MAX_LEN(MAX_LEN)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_runs();
    foreach (run_row[j]) run_row[j] = 0;
    first_row = 1'b1;
    best_run  = 0;
  endfunction

  function automatic void lcs_track(lcs_item_t it);
    int unsigned run;
    lcs_result_t res;
    if (it.kind == REQ_PATTERN) begin
      if (pat_done) begin
        pat_len  = 0;
        ovf_seen = 1'b0;
        pat_done = 1'b0;
        clear_runs();
      end
      if (it.has_char) begin
        if (pat_len < MAX_LEN) begin
          pat_mem[pat_len] = it.ch;
          pat_len++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      if (it.is_last) pat_done = 1'b1;
    end else begin
      if (it.has_char) begin
        // top down so the lower cell still holds the previous row
        for (int j = int'(pat_len) - 1; j >= 0; j--) begin
          if (pat_mem[j] != it.ch) run = 0;
          else if (first_row || j == 0) run = 1;
          else run = run_row[j-1] + 1;
          run_row[j] = run;
          if (run > best_run) best_run = run;
        end
        first_row = 1'b0;
      end
      if (it.is_last) begin
        res.match_len = MATCH_W'((best_run > MATCH_MAX) ? MATCH_MAX : best_run);
        res.overflow  = ovf_seen;
        expected_q = {expected_q, res};
        clear_runs();
      end
    end
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 45;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char(logic [CHAR_W-1:0] base, bit wide);
    if (wide) return CHAR_W'($urandom_range(0, 255));
    return base + CHAR_W'($urandom_range(0, 2));
  endfunction

  task automatic queue_item(req_kind_e kind, logic [CHAR_W-1:0] ch, bit has, bit last);
    lcs_item_t it;
    it.kind     = kind;
    it.ch       = ch;
    it.has_char = has;
    it.is_last  = last;
    pending_q = {pending_q, it};
    if (has || last) n_real++;
  endtask

  task automatic queue_string(req_kind_e kind, char_q_t s, bit mark_end);
    bit tail_empty;
    tail_empty = mark_end && (s.size() == 0 || $urandom_range(0, 3) == 0);
    foreach (s[i]) queue_item(kind, s[i], 1'b1, mark_end && !tail_empty && i == s.size() - 1);
    if (tail_empty) queue_item(kind, CHAR_W'($urandom), 1'b0, 1'b1);
  endtask

  // input side
  lcs_item_t   cur_item = '0;
  bit          in_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned in_pct = 0;
  int unsigned in_cyc = 0;

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready_o) begin
      lcs_track(cur_item);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    logic nv;
    nv       = s_axis_tvalid && !in_taken;
    in_taken = 1'b0;
    in_cyc++;
    if (in_cyc % 50 == 0) in_pct = pick_pct();
    if (rst_ni && !nv) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_q.size() > 0) begin
        cur_item = pending_q.pop_front();
        nv       = 1'b1;
        if (pending_q.size() > CALM_LEFT && $urandom_range(0, 99) < in_pct)
          in_gap = $urandom_range(1, 13);
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= {7'b0, cur_item.has_char, cur_item.ch};
    s_axis_tuser  <= cur_item.kind;
    s_axis_tlast  <= cur_item.is_last;
  end

  // output side
  int unsigned out_gap = 0;
  int unsigned out_pct = 0;
  int unsigned out_cyc = 0;

  always @(posedge clk_i) begin
    lcs_result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      got = m_axis_tdata_o;
      if (expected_q.size() == 0) begin
        $error("unexpected result: match_len %0d, pattern_overflow %0d",
               got.match_len, got.overflow);
        n_err++;
      end else begin
        want = expected_q.pop_front();
        if (got.match_len !== want.match_len) begin
          $error("match_len: expected %0d, actual %0d", want.match_len, got.match_len);
          n_err++;
        end
        if (got.overflow !== want.overflow) begin
          $error("pattern_overflow: expected %0d, actual %0d", want.overflow, got.overflow);
          n_err++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_cyc++;
    if (out_cyc % 50 == 0) out_pct = pick_pct();
    if (out_gap > 0) begin
      out_gap--;
      m_axis_tready <= 1'b0;
    end else if (pending_q.size() > CALM_LEFT && $urandom_range(0, 99) < out_pct) begin
      out_gap = $urandom_range(0, 12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    char_q_t           pat, txt;
    logic [CHAR_W-1:0] base;
    bit                wide;
    int unsigned       len, start, span;

    // text before any pattern, empty text, items with no effect
    queue_string(REQ_TEXT, {8'h00}, 1'b1);
    queue_item(REQ_TEXT, 8'hff, 1'b0, 1'b1);
    queue_item(REQ_PATTERN, 8'h5a, 1'b0, 1'b0);
    queue_item(REQ_TEXT, 8'ha5, 1'b0, 1'b0);
    // text against an unfinished pattern, then the pattern goes on
    queue_string(REQ_PATTERN, {8'h61, 8'h62}, 1'b0);
    queue_string(REQ_TEXT, {8'h62}, 1'b1);
    queue_string(REQ_PATTERN, {8'hff}, 1'b1);
    // several texts on one pattern
    queue_string(REQ_TEXT, {8'h00, 8'h61, 8'h62, 8'hff}, 1'b1);
    queue_string(REQ_TEXT, {8'h62, 8'hff, 8'h62}, 1'b1);
    // new pattern after a complete one
    queue_string(REQ_PATTERN, {8'h00, 8'hff}, 1'b1);
    queue_string(REQ_TEXT, {8'hff, 8'h00, 8'hff}, 1'b1);
    // empty pattern
    queue_item(REQ_PATTERN, 8'h00, 1'b0, 1'b1);
    queue_string(REQ_TEXT, {8'h41}, 1'b1);

    // overlong pattern, text holding all stored characters
    pat  = {};
    base = CHAR_W'($urandom);
    repeat (MAX_LEN + 6) pat = {pat, pick_char(base, 1'b0)};
    queue_string(REQ_PATTERN, pat, 1'b1);
    queue_string(REQ_TEXT, pat[0:MAX_LEN-1], 1'b1);
    n_texts++;

    while (n_real < N_ITEMS || n_texts < MIN_TEXTS) begin
      base = CHAR_W'($urandom);
      wide = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
        default: len = $urandom_range(1, 12);
      endcase
      pat = {};
      repeat (len) pat = {pat, pick_char(base, wide)};
      queue_string(REQ_PATTERN, pat, $urandom_range(0, 7) != 0);
      if ($urandom_range(0, 5) == 0)
        queue_item(req_kind_e'($urandom_range(0, 1)), CHAR_W'($urandom), 1'b0, 1'b0);
      repeat ($urandom_range(1, 3)) begin
        txt = {};
        repeat ($urandom_range(0, 4)) txt = {txt, pick_char(base, wide)};
        if (pat.size() > 0 && $urandom_range(0, 3) != 0) begin
          start = $urandom_range(0, pat.size() - 1);
          span  = ($urandom_range(0, 3) == 0) ? pat.size() - start
                                              : $urandom_range(1, pat.size() - start);
          for (int k = start; k < start + span; k++) txt = {txt, pat[k]};
        end
        repeat ($urandom_range(0, 4)) txt = {txt, pick_char(base, wide)};
        queue_string(REQ_TEXT, txt, 1'b1);
        n_texts++;
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (MAX_LEN + 16) @(posedge clk_i);

    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
